>>> rtl/cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_pkg
// Types and codes shared by the chunked body decoder and its result queue.
// ----------------------------------------------------------------------------
package cbd_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_DATA  = 2'd0;
	localparam kind_t KIND_END   = 2'd1;
	localparam kind_t KIND_TRUNC = 2'd2;
	localparam kind_t KIND_OVF   = 2'd3;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} out_item_t;

	// results of one input byte: first always present, second when two is set
	typedef struct packed {
		logic      two;
		out_item_t first;
		out_item_t second;
	} rslt_pair_t;

	typedef struct packed {
		logic room;
		logic full;
	} q_status_t;

endpackage

>>> rtl/cbd_rslt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_rslt_fifo
// Two-entry queue of result pairs, unpacked onto the result channel one
// transaction at a time.
// ----------------------------------------------------------------------------
module cbd_rslt_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cbd_pkg::rslt_pair_t push_data,
	output cbd_pkg::q_status_t  status,
	output logic                result_valid,
	input  logic                result_ready,
	output cbd_pkg::out_item_t  result
);

	cbd_pkg::rslt_pair_t entry_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                second_q;
	logic                take;
	logic                pop;

	assign result_valid = (count_q != 2'd0);
	assign take         = result_valid && result_ready;
	assign pop          = take && (second_q || !entry_q[rd_ptr_q].two);
	assign result       = second_q ? entry_q[rd_ptr_q].second : entry_q[rd_ptr_q].first;
	assign status.full  = (count_q == 2'd2);
	assign status.room  = !status.full || pop;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			second_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				second_q <= 1'b0;
			end else if (take) begin
				second_q <= 1'b1;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> status.room)
		else $error("result queue written while full");

	a_second_only_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> result_valid && entry_q[rd_ptr_q].two)
		else $error("second result shown for a single-result entry");
`endif

endmodule

>>> rtl/chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_body_decoder
// HTTP chunked transfer decoder: raw body bytes in, payload bytes and
// end-of-body, truncation and size-overflow markers out.
// ----------------------------------------------------------------------------
// One body byte is taken per clock while the result queue has room. Each byte
// is held in an input register, decoded by the size-line/data state machine
// once the queue has room and its results written to a two-entry result queue
// that drives the result port. A byte yields at most two results (a
// payload byte followed by a truncation marker when it carries end_of_input);
// the result port moves one per cycle, so such a byte takes two transfers on the
// output side. The sustained rate is therefore one byte per cycle, set by the
// single result port, while the consumer keeps result_ready high. SIZE_BITS sets
// the width of the chunk size and remaining-byte count.
// ----------------------------------------------------------------------------
module chunked_body_decoder #(
	parameter int SIZE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  cbd_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output cbd_pkg::out_item_t result
);

	typedef enum logic [2:0] {
		PH_WS,
		PH_HEX,
		PH_REST,
		PH_DATA,
		PH_TRAIL,
		PH_DONE,
		PH_ERROR
	} phase_t;

	logic                 valid_s1;
	cbd_pkg::in_item_t    item_s1;
	cbd_pkg::q_status_t   q_status;
	logic                 advance;

	phase_t               phase_q, phase_n;
	logic [SIZE_BITS-1:0] acc_q, acc_n;
	logic [SIZE_BITS-1:0] rem_q, rem_n;
	logic                 saw_q, saw_n;

	logic                 is_lf;
	logic                 is_blank;
	logic                 hex_ok;
	logic [3:0]           hex_val;
	logic                 do_hex;
	logic                 fin;
	logic                 prim;
	cbd_pkg::out_item_t   prim_item;
	logic                 trunc;
	cbd_pkg::rslt_pair_t  pair;
	logic                 push;

	assign advance    = valid_s1 && q_status.room;
	assign item_ready = !valid_s1 || q_status.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign is_lf    = (item_s1.byte_value == 8'h0A);
	assign is_blank = (item_s1.byte_value == 8'h20) || (item_s1.byte_value == 8'h09) ||
	                  (item_s1.byte_value == 8'h0B) || (item_s1.byte_value == 8'h0C) ||
	                  (item_s1.byte_value == 8'h0D);

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = item_s1.byte_value[3:0];
		if (item_s1.byte_value >= 8'h30 && item_s1.byte_value <= 8'h39) begin
			hex_val = item_s1.byte_value[3:0];
		end else if ((item_s1.byte_value >= 8'h61 && item_s1.byte_value <= 8'h66) ||
		             (item_s1.byte_value >= 8'h41 && item_s1.byte_value <= 8'h46)) begin
			hex_val = item_s1.byte_value[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		rem_n     = rem_q;
		saw_n     = saw_q;
		do_hex    = 1'b0;
		fin       = 1'b0;
		prim      = 1'b0;
		prim_item = '0;
		trunc     = 1'b0;

		unique case (phase_q)
			PH_WS: begin
				if (is_lf) begin
					fin = 1'b1;
				end else if (!is_blank) begin
					phase_n = PH_HEX;
					do_hex  = 1'b1;
				end
			end
			PH_HEX: begin
				do_hex = 1'b1;
			end
			PH_REST: begin
				fin = is_lf;
			end
			PH_DATA: begin
				prim                = 1'b1;
				prim_item.kind      = cbd_pkg::KIND_DATA;
				prim_item.data_byte = item_s1.byte_value;
				rem_n               = rem_q - {{(SIZE_BITS-1){1'b0}}, 1'b1};
				if (rem_n == '0) begin
					phase_n = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				if (is_lf) begin
					phase_n = PH_WS;
					acc_n   = '0;
					saw_n   = 1'b0;
				end
			end
			PH_DONE, PH_ERROR: begin
			end
			default: begin
				phase_n = PH_ERROR;
			end
		endcase

		if (do_hex) begin
			if (is_lf) begin
				fin = 1'b1;
			end else if (!hex_ok) begin
				phase_n = PH_REST;
			end else if (acc_q[SIZE_BITS-1 -: 4] != 4'd0) begin
				prim           = 1'b1;
				prim_item.kind = cbd_pkg::KIND_OVF;
				phase_n        = PH_ERROR;
			end else begin
				acc_n = {acc_q[SIZE_BITS-5:0], hex_val};
				saw_n = 1'b1;
			end
		end

		if (fin) begin
			if (!saw_q || acc_q == '0) begin
				prim           = 1'b1;
				prim_item.kind = cbd_pkg::KIND_END;
				phase_n        = PH_DONE;
			end else begin
				rem_n   = acc_q;
				phase_n = PH_DATA;
			end
		end

		if (item_s1.end_of_input) begin
			trunc   = (phase_n != PH_DONE) && (phase_n != PH_ERROR);
			phase_n = PH_WS;
			acc_n   = '0;
			rem_n   = '0;
			saw_n   = 1'b0;
		end
	end

	always_comb begin
		pair             = '0;
		pair.second.kind = cbd_pkg::KIND_TRUNC;
		if (prim) begin
			pair.first = prim_item;
			pair.two   = trunc;
		end else begin
			pair.first.kind = cbd_pkg::KIND_TRUNC;
		end
	end

	assign push = advance && (prim || trunc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			acc_q   <= '0;
			rem_q   <= '0;
			saw_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			rem_q   <= rem_n;
			saw_q   <= saw_n;
		end
	end

	cbd_rslt_fifo u_rslt_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_data    (pair),
		.status       (q_status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("held transaction lost or changed while stalled");

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("data phase with nothing left to pass");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_input |=> phase_q == PH_WS && acc_q == '0 && !saw_q)
		else $error("state not restarted after end of input");
`endif

endmodule

>>> tb/sv/cbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_checker
// Watches both channels of the chunked body decoder. It decodes every accepted
// body byte itself, queues the expected results and compares each accepted
// result, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module cbd_checker #(
	parameter int SIZE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  cbd_pkg::in_item_t  item,
	input  logic               result_valid,
	input  logic               result_ready,
	input  cbd_pkg::out_item_t result,
	output int                 fail_count,
	output int                 outstanding,
	output int                 results_checked
);

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;

	typedef enum logic [2:0] {
		P_BLANK,
		P_DIGITS,
		P_EXT,
		P_PAYLOAD,
		P_TRAILER,
		P_FINISHED,
		P_FAULT
	} dec_phase_t;

	dec_phase_t           pred_phase;
	logic [SIZE_BITS-1:0] size_acc;
	logic [SIZE_BITS-1:0] left_count;
	logic                 have_digit;
	cbd_pkg::out_item_t   expected_results[$];
	int                   errors;
	int                   checked;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic clear_decoder();
		pred_phase = P_BLANK;
		size_acc   = '0;
		left_count = '0;
		have_digit = 1'b0;
	endtask

	task automatic expect_marker(input cbd_pkg::kind_t k);
		expected_results.push_back(cbd_pkg::out_item_t'{kind: k, data_byte: 8'h00});
	endtask

	// LF closing a size line: either a chunk starts or the body is over
	task automatic close_size_line();
		if (!have_digit || size_acc == '0) begin
			expect_marker(cbd_pkg::KIND_END);
			pred_phase = P_FINISHED;
		end else begin
			left_count = size_acc;
			pred_phase = P_PAYLOAD;
		end
	endtask

	task automatic decode_byte(input logic [7:0] c, input logic eoi);
		int   digit;
		logic in_digits;
		in_digits = 1'b0;
		case (pred_phase)
			P_BLANK: begin
				if (c == CH_LF)
					close_size_line();
				else if (!(c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR)) begin
					pred_phase = P_DIGITS;
					in_digits  = 1'b1;
				end
			end
			P_DIGITS: in_digits = 1'b1;
			P_EXT: begin
				if (c == CH_LF)
					close_size_line();
			end
			P_PAYLOAD: begin
				expected_results.push_back(
					cbd_pkg::out_item_t'{kind: cbd_pkg::KIND_DATA, data_byte: c});
				left_count = left_count - 1'b1;
				if (left_count == '0)
					pred_phase = P_TRAILER;
			end
			P_TRAILER: begin
				if (c == CH_LF) begin
					pred_phase = P_BLANK;
					size_acc   = '0;
					have_digit = 1'b0;
				end
			end
			default: ;
		endcase

		if (in_digits) begin
			if (c >= "0" && c <= "9")
				digit = c - "0";
			else if (c >= "a" && c <= "f")
				digit = c - "a" + 10;
			else if (c >= "A" && c <= "F")
				digit = c - "A" + 10;
			else
				digit = -1;

			if (c == CH_LF) begin
				close_size_line();
			end else if (digit < 0) begin
				pred_phase = P_EXT;
			end else if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
				expect_marker(cbd_pkg::KIND_OVF);
				pred_phase = P_FAULT;
			end else begin
				size_acc   = {size_acc[SIZE_BITS-5:0], digit[3:0]};
				have_digit = 1'b1;
			end
		end

		if (eoi) begin
			if (pred_phase != P_FINISHED && pred_phase != P_FAULT)
				expect_marker(cbd_pkg::KIND_TRUNC);
			clear_decoder();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			expected_results.delete();
			errors = 0;
			checked = 0;
			fail_count <= 0;
			outstanding <= 0;
			results_checked <= 0;
		end else begin
			// a result leaving now cannot belong to a byte entering now
			if (result_valid && result_ready) begin
				checked++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d data %02h",
						result.kind, result.data_byte));
				end else begin
					cbd_pkg::out_item_t want;
					want = expected_results.pop_front();
					if (result.kind !== want.kind)
						report_mismatch($sformatf("result %0d kind %0d, wanted %0d",
							checked, result.kind, want.kind));
					if (result.data_byte !== want.data_byte)
						report_mismatch($sformatf("result %0d data %02h, wanted %02h",
							checked, result.data_byte, want.data_byte));
				end
			end
			if (item_valid && item_ready)
				decode_byte(item.byte_value, item.end_of_input);
			fail_count <= errors;
			outstanding <= expected_results.size();
			results_checked <= checked;
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the chunked body decoder: a few hand-built bodies, then random
// well-formed, cut-short, oversize, prefixed and noise bodies, with random
// idling on both channels, a long result stall and input drains. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SIZE_BITS   = 32;
	localparam int N_ITEMS     = 1300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int RX_HOLD     = 200;
	localparam int TAIL_CYCLES = 16;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	cbd_pkg::in_item_t  item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	cbd_pkg::out_item_t result;

	int fail_count;
	int outstanding;
	int results_checked;

	logic [7:0] body_bytes[$];
	int         bodies_sent = 0;
	int         bytes_sent = 0;
	bit         burst_mode = 1'b0;
	bit         stall_request = 1'b0;
	int         quiet = 0;

	chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	cbd_checker #(.SIZE_BITS(SIZE_BITS)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] hex_digit(input int d, input bit upper);
		if (d < 10)
			return 8'("0" + d);
		return upper ? 8'("A" + d - 10) : 8'("a" + d - 10);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 40);
		return $urandom_range(100, 300);
	endfunction

	task automatic put_junk(input int n, input bit no_lf);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (no_lf && b == CH_LF)
				b = 8'h00;
			body_bytes.push_back(b);
		end
	endtask

	task automatic put_blanks();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 4))
					0: body_bytes.push_back(CH_SP);
					1: body_bytes.push_back(CH_TAB);
					2: body_bytes.push_back(CH_VT);
					3: body_bytes.push_back(CH_FF);
					default: body_bytes.push_back(CH_CR);
				endcase
			end
		end
	endtask

	task automatic put_size_line(input logic [SIZE_BITS-1:0] size);
		logic [7:0]           digits[$];
		logic [SIZE_BITS-1:0] v;
		int                   r;
		put_blanks();
		v = size;
		do begin
			digits.push_front(hex_digit(int'(v[3:0]), 1'($urandom_range(0, 1))));
			v = v >> 4;
		end while (v != '0);
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) digits.push_front("0");
		foreach (digits[i])
			body_bytes.push_back(digits[i]);
		r = $urandom_range(0, 99);
		if (r < 20) begin
			body_bytes.push_back(";");
			put_junk($urandom_range(0, 6), 1'b1);
		end else if (r < 30) begin
			body_bytes.push_back(CH_SP);
			put_junk($urandom_range(0, 4), 1'b1);
		end
		if ($urandom_range(0, 9) != 0)
			body_bytes.push_back(CH_CR);
		body_bytes.push_back(CH_LF);
	endtask

	task automatic put_chunk(input int size);
		put_size_line(SIZE_BITS'(size));
		put_junk(size, 1'b0);
		if ($urandom_range(0, 99) < 85) begin
			body_bytes.push_back(CH_CR);
		end else begin
			put_junk($urandom_range(0, 4), 1'b1);
		end
		body_bytes.push_back(CH_LF);
	endtask

	task automatic build_wellformed();
		repeat ($urandom_range(0, 4)) put_chunk(pick_size());
		if ($urandom_range(0, 4) == 0) begin
			// terminator line with no size at all
			put_blanks();
			body_bytes.push_back(CH_LF);
		end else begin
			put_size_line('0);
		end
		if ($urandom_range(0, 3) == 0)
			put_junk($urandom_range(1, 3), 1'b0);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		item <= cbd_pkg::in_item_t'{byte_value: b, end_of_input: eoi};
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		bytes_sent++;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_body();
		foreach (body_bytes[i])
			send_byte(body_bytes[i], i == body_bytes.size() - 1);
		body_bytes.delete();
		bodies_sent++;
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side: random ready pattern, plus one long hold-off on request
	initial begin
		int n;
		int r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_request) begin
				result_ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				stall_request = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					result_ready <= 1'b1;
					n = $urandom_range(1, 30);
				end else if (r < 95) begin
					result_ready <= 1'b0;
					n = $urandom_range(1, 3);
				end else begin
					result_ready <= 1'b0;
					n = $urandom_range(10, 40);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= IDLE_LIMIT) begin
					$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		int                   r;
		int                   cut;
		logic [SIZE_BITS-1:0] big;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bare LF ends the body, trailing byte dropped
		body_bytes = '{CH_LF, 8'h00};
		send_body();
		// all blanks, extension, one data byte, then 0x prefix as terminator
		body_bytes = '{CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR, "1", ";", CH_LF, 8'hFF, CH_LF,
			"0", "x", CH_LF};
		send_body();
		// oversize
		repeat (9) body_bytes.push_back("F");
		send_body();
		// data byte on the last transaction: payload then truncation
		body_bytes = '{"1", CH_LF, 8'h00};
		send_body();

		while (bytes_sent < N_ITEMS) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			if (bodies_sent == 6) begin
				stall_request = 1'b1;
				burst_mode = 1'b1;
				while (stall_request) begin
					build_wellformed();
					send_body();
				end
			end
			if (bodies_sent % 25 == 12)
				wait_drain();
			r = $urandom_range(0, 99);
			if (r < 65) begin
				build_wellformed();
			end else if (r < 80) begin
				if ($urandom_range(0, 3) == 0) begin
					big = SIZE_BITS'($urandom());
					big[SIZE_BITS-1] = 1'b1;
					put_size_line(big);
					put_junk($urandom_range(0, 5), 1'b0);
				end else begin
					build_wellformed();
					cut = $urandom_range(1, body_bytes.size());
					while (body_bytes.size() > cut)
						void'(body_bytes.pop_back());
				end
			end else if (r < 88) begin
				put_blanks();
				repeat ($urandom_range(0, 2)) body_bytes.push_back("0");
				body_bytes.push_back(hex_digit(int'($urandom_range(1, 15)),
					1'($urandom_range(0, 1))));
				repeat (SIZE_BITS / 4 + $urandom_range(0, 2))
					body_bytes.push_back(hex_digit(int'($urandom_range(0, 15)),
						1'($urandom_range(0, 1))));
				put_junk($urandom_range(0, 4), 1'b0);
			end else if (r < 94) begin
				case ($urandom_range(0, 3))
					0: body_bytes.push_back("+");
					1: body_bytes.push_back("-");
					2: begin
						body_bytes.push_back("0");
						body_bytes.push_back("x");
					end
					default: begin
						body_bytes.push_back("0");
						body_bytes.push_back("X");
					end
				endcase
				repeat ($urandom_range(1, 3))
					body_bytes.push_back(hex_digit(int'($urandom_range(0, 15)),
						1'($urandom_range(0, 1))));
				body_bytes.push_back(CH_CR);
				body_bytes.push_back(CH_LF);
				put_junk($urandom_range(0, 3), 1'b0);
			end else begin
				put_junk($urandom_range(1, 12), 1'b0);
			end
			send_body();
		end

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d bodies, %0d bytes in, %0d results compared",
			bodies_sent, bytes_sent, results_checked);
		$display("summary: well-formed, cut-short, oversize, prefixed and noise bodies, "
			, "long output stall and input drains");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
